/* hdl/fpba_pkg.sv */
// fpba_pkg: request and result payload types, command and status structs,
// and field, mode, policy and register codes for the fit-policy block allocator
// no dependencies
package fpba_pkg;

    localparam int FIELD_INDEX_W = 4;
    localparam int FIELD_SIZE_W  = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 5;

    // input mode codes
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    // placement policy codes (code three behaves as first fit)
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic [FIELD_INDEX_W-1:0] entry_index;
        logic [FIELD_SIZE_W-1:0]  size;
    } t_in_req;

    typedef struct packed {
        logic                     granted;
        logic [FIELD_INDEX_W-1:0] block_index;
        logic [FIELD_SIZE_W-1:0]  base_size;
        logic [FIELD_SIZE_W-1:0]  remaining_size;
    } t_out_res;

    // controller to datapath
    typedef struct packed {
        logic load;     // write a table entry from the input request
        logic capture;  // latch request size and search limit, clear search
        logic scan;     // walk the table, one entry read per cycle
        logic fetch;    // read original size of the pick, update its free size
        logic emit;     // load the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic found;
        logic out_free;
    } t_status;

endpackage

/* hdl/fpba_ctrl.sv */
// fpba_ctrl: sequencing state machine of the allocator
// depends on fpba_pkg (t_cmd, t_status, mode codes)
module fpba_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_mode,
    output logic             o_in_stall,
    output fpba_pkg::t_cmd   o_cmd,
    input  fpba_pkg::t_status i_status
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_FETCH = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_in_mode == fpba_pkg::MODE_REQUEST) begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_SCAN;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = i_status.found ? S_FETCH : S_DONE;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/fpba_dpath.sv */
// fpba_dpath: block table memories, scan counter, fit comparator,
// configuration registers and output register of the allocator
// depends on fpba_pkg (payload types, t_cmd, t_status, codes)
module fpba_dpath #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  fpba_pkg::t_in_req                  i_in_data,
    input  fpba_pkg::t_cmd                     i_cmd,
    output fpba_pkg::t_status                  o_status,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output fpba_pkg::t_out_res                 o_out_data
);

    localparam int AW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW  = $clog2(MAX_BLOCKS + 1);
    localparam int IW  = (AW > fpba_pkg::FIELD_INDEX_W) ? AW : fpba_pkg::FIELD_INDEX_W;
    localparam int SW  = (SIZE_BITS > fpba_pkg::FIELD_SIZE_W) ? SIZE_BITS
                                                               : fpba_pkg::FIELD_SIZE_W;

    // configuration
    logic [1:0]                      r_fit_policy;
    logic [fpba_pkg::CFG_DATA_W-1:0] r_block_count;

    // block table
    logic [SIZE_BITS-1:0] r_avail_mem [MAX_BLOCKS];
    logic [SIZE_BITS-1:0] r_orig_mem  [MAX_BLOCKS];
    logic [SIZE_BITS-1:0] r_avail_q;
    logic [SIZE_BITS-1:0] r_orig_q;

    // search state
    logic [SIZE_BITS-1:0] r_sz;
    logic [CW-1:0]        r_limit;
    logic [CW-1:0]        r_rd_idx;
    logic                 r_cmp_valid;
    logic [AW-1:0]        r_cmp_idx;
    logic                 r_found;
    logic [AW-1:0]        r_pick;
    logic [SIZE_BITS-1:0] r_best;
    logic [SIZE_BITS-1:0] r_rem;

    // output register
    logic                 r_out_valid;
    fpba_pkg::t_out_res   r_out_data;

    logic [SW-1:0]        w_in_wide;
    logic [SIZE_BITS-1:0] w_in_size;
    logic [IW-1:0]        w_idx_wide;
    logic [AW-1:0]        w_ld_addr;
    logic                 w_ld_ok;
    logic [CW-1:0]        w_limit;
    logic                 w_issue;
    logic                 w_fits;
    logic                 w_take;
    logic [SIZE_BITS-1:0] w_new_rem;
    logic [SW-1:0]        w_orig_wide;
    logic [SW-1:0]        w_rem_wide;
    logic [IW-1:0]        w_pick_wide;
    logic                 w_out_free;

    // field width adaptation
    assign w_in_wide   = SW'(i_in_data.size);
    assign w_in_size   = w_in_wide[SIZE_BITS-1:0];
    assign w_idx_wide  = IW'(i_in_data.entry_index);
    assign w_ld_addr   = w_idx_wide[AW-1:0];
    assign w_ld_ok     = (32'(i_in_data.entry_index) < 32'(MAX_BLOCKS));
    assign w_limit     = (32'(r_block_count) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS)
                                                                : CW'(r_block_count);
    assign w_orig_wide = SW'(r_orig_q);
    assign w_rem_wide  = SW'(r_rem);
    assign w_pick_wide = IW'(r_pick);

    assign w_issue   = i_cmd.scan && (r_rd_idx < r_limit);
    assign w_fits    = (r_sz <= r_avail_q);
    assign w_take    = r_cmp_valid && w_fits &&
                       (!r_found ||
                        ((r_fit_policy == fpba_pkg::POL_BEST)  && (r_avail_q < r_best)) ||
                        ((r_fit_policy == fpba_pkg::POL_WORST) && (r_avail_q > r_best)));
    assign w_new_rem = r_best - r_sz;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_status.scan_done = (r_rd_idx >= r_limit) && !r_cmp_valid;
    assign o_status.found     = r_found;
    assign o_status.out_free  = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_policy  <= fpba_pkg::POL_FIRST;
            r_block_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fpba_pkg::CFG_FIT_POLICY:  r_fit_policy  <= i_cfg_wdata[1:0];
                fpba_pkg::CFG_BLOCK_COUNT: r_block_count <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // table memories, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_ld_ok) begin
            r_avail_mem[w_ld_addr] <= w_in_size;
        end else if (i_cmd.fetch) begin
            r_avail_mem[r_pick] <= w_new_rem;
        end
        if (w_issue) begin
            r_avail_q <= r_avail_mem[r_rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_ld_ok) begin
            r_orig_mem[w_ld_addr] <= w_in_size;
        end
        if (i_cmd.fetch) begin
            r_orig_q <= r_orig_mem[r_pick];
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx    <= '0;
            r_limit     <= '0;
            r_cmp_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_cmp_valid <= w_issue;
            if (i_cmd.capture) begin
                r_rd_idx <= '0;
                r_limit  <= w_limit;
                r_found  <= 1'b0;
            end else begin
                if (w_issue) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
                if (w_take) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    // search payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sz <= w_in_size;
        end
        if (w_issue) begin
            r_cmp_idx <= r_rd_idx[AW-1:0];
        end
        if (w_take) begin
            r_pick <= r_cmp_idx;
            r_best <= r_avail_q;
        end
        if (i_cmd.fetch) begin
            r_rem <= w_new_rem;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data.granted        <= r_found;
            r_out_data.block_index    <= r_found ? w_pick_wide[fpba_pkg::FIELD_INDEX_W-1:0]
                                                 : '0;
            r_out_data.base_size      <= r_found ? w_orig_wide[fpba_pkg::FIELD_SIZE_W-1:0]
                                                 : '0;
            r_out_data.remaining_size <= r_found ? w_rem_wide[fpba_pkg::FIELD_SIZE_W-1:0]
                                                 : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* hdl/fit_policy_block_allocator.sv */
// fit_policy_block_allocator: a load is written to the table without leaving idle; a request
// reads n = min(block_count, MAX_BLOCKS) entries, one per cycle on the single read port, then
// fetches the pick when one fits, and its result waits to enter the output register while a
// held result stalls it; the next request is taken in the cycle after that register loads
// reset (synchronous, active low) clears policy to first fit, count to zero and the sequencer
module fit_policy_block_allocator #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  fpba_pkg::t_in_req               i_in_data,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output fpba_pkg::t_out_res              o_out_data
);

    // command and status between sequencer and datapath
    fpba_pkg::t_cmd    w_cmd;
    fpba_pkg::t_status w_status;

    // sequencer: idle takes a request, loads finish at once,
    // allocation requests walk scan, fetch (only when one fits) and done
    fpba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in_data.mode),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    // datapath: table memories, fit comparator with running pick,
    // free size update and output register; table contents stay undefined until loaded
    fpba_dpath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
